### sv/desa_pkg.sv
// shared constants and types of the double-ended stack allocator
package desa_pkg;

   localparam int DEF_ARENA_BYTES = 65536;
   localparam int DEF_ALIGN_BYTES = 8;

   localparam int REQ_BYTES_W = 16;
   localparam int POP_COUNT_W = 16;
   localparam int OFFSET_W    = 16;
   localparam int STATUS_W    = 2;

   localparam logic ACT_ALLOC  = 1'b0;
   localparam logic ACT_POP    = 1'b1;
   localparam logic END_BOTTOM = 1'b0;
   localparam logic END_TOP    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

endpackage

### sv/desa_size_ram.sv
// block size store: one write port, one registered read port
module desa_size_ram
   import desa_pkg::*;
#(
   parameter int DEPTH  = DEF_ARENA_BYTES / DEF_ALIGN_BYTES,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/double_ended_stack_allocator.sv
// double-ended stack allocator: two stacks sharing one arena, top level
//
// req channel: one transaction is either an allocate (action 0) or a pop
// (action 1) on the bottom end (end_select 0) or the top end (end_select 1).
// rsp channel: exactly one transaction per request, carrying block_offset
// and status (0 ok, 1 out of space, 2 pop on empty end).
// Allocate passes from acceptance to rsp_valid through the reciprocal
// multiply that rounds the size to the alignment, then the compare and
// metadata write, then the load of the output register.
// Pop: each unwound block needs one read of the size store (registered
// read port) and one update of the end pointer.
// An empty pop goes from idle straight to the done state.
// req_stall is high while a transaction is in progress; a new request is
// taken while a finished response still waits in the output register.
// The next request can be taken in the cycle after the response is loaded.
// When rsp_stall is high the response holds and the sequencer waits for it.
// Synchronous reset empties both stacks; the size store is not cleared.
module double_ended_stack_allocator
   import desa_pkg::*;
#(
   parameter int ARENA_BYTES = DEF_ARENA_BYTES,
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic                   req_end_select,
   input  logic [REQ_BYTES_W-1:0] req_request_bytes,
   input  logic [POP_COUNT_W-1:0] req_pop_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OFFSET_W-1:0]    rsp_block_offset,
   output logic [STATUS_W-1:0]    rsp_status
);

   localparam int TOP_U    = ARENA_BYTES / ALIGN_BYTES;
   localparam int UNIT_W   = $clog2(TOP_U + 1);
   localparam int ADDR_W   = $clog2(TOP_U);
   localparam int NUM_W    = REQ_BYTES_W + 1;
   localparam int SHIFT_L  = $clog2(ALIGN_BYTES);
   localparam int RECIP_S  = NUM_W + SHIFT_L;
   localparam int RECIP_M  = ((1 << RECIP_S) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int M_W      = NUM_W + 2;
   localparam int Q_W      = NUM_W - 2;
   localparam int PROD_W   = RECIP_S + Q_W;
   localparam int TOT_W    = Q_W + 1;
   localparam int CMP_W    = TOT_W + 2;
   localparam int OFFP_W   = UNIT_W + SHIFT_L + 1;

   localparam logic [UNIT_W-1:0] TOP_EDGE_U = UNIT_W'(TOP_U);
   localparam logic [M_W-1:0]    RECIP_M_V  = M_W'(RECIP_M);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ALLOC,
      ST_POP_RD,
      ST_POP_UPD,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic                   end_ff, end_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [POP_COUNT_W-1:0] count_ff, count_in;
   logic [UNIT_W-1:0]      bottom_ff, bottom_in;
   logic [UNIT_W-1:0]      top_ff, top_in;
   logic [UNIT_W-1:0]      result_idx_ff, result_idx_in;
   status_type             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]    rsp_offset_ff, rsp_offset_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [UNIT_W-1:0]      ram_wr_data;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [UNIT_W-1:0]      ram_rd_data;

   logic [Q_W-1:0]         quot;
   logic [TOT_W-1:0]       total_u;
   logic                   fits;
   logic [UNIT_W-1:0]      bottom_minus1;
   logic [OFFP_W-1:0]      offset_bytes;

   assign quot          = prod_ff[RECIP_S +: Q_W];
   assign total_u       = TOT_W'(quot) + TOT_W'(1);
   assign fits          = (CMP_W'(bottom_ff) + CMP_W'(total_u)) < CMP_W'(top_ff);
   assign bottom_minus1 = bottom_ff - UNIT_W'(1);
   assign offset_bytes  = OFFP_W'(result_idx_ff) * OFFP_W'(ALIGN_BYTES);
   assign ram_rd_addr   = (end_ff == END_TOP) ? top_ff[ADDR_W-1:0]
                                              : bottom_minus1[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      end_in        = end_ff;
      num_in        = num_ff;
      prod_in       = prod_ff;
      count_in      = count_ff;
      bottom_in     = bottom_ff;
      top_in        = top_ff;
      result_idx_in = result_idx_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = top_ff[ADDR_W-1:0];
      ram_wr_data   = UNIT_W'(total_u);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               end_in    = req_end_select;
               num_in    = NUM_W'(req_request_bytes) + NUM_W'(ALIGN_BYTES - 1);
               count_in  = req_pop_count;
               status_in = STATUS_OK;
               if (req_action == ACT_ALLOC) begin
                  state_in = ST_MUL;
               end else if (req_end_select == END_TOP) begin
                  result_idx_in = top_ff;
                  if (top_ff >= TOP_EDGE_U) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_POP_RD;
                  end
               end else begin
                  result_idx_in = bottom_ff;
                  if (bottom_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_POP_RD;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(num_ff) * PROD_W'(RECIP_M_V);
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            if (!fits) begin
               status_in     = STATUS_NO_SPACE;
               result_idx_in = '0;
            end else if (end_ff == END_TOP) begin
               top_in        = top_ff - UNIT_W'(total_u);
               ram_wr_en     = 1'b1;
               ram_wr_addr   = top_in[ADDR_W-1:0];
               result_idx_in = top_in + UNIT_W'(1);
            end else begin
               bottom_in     = bottom_ff + UNIT_W'(total_u);
               ram_wr_en     = 1'b1;
               ram_wr_addr   = ADDR_W'(bottom_in - UNIT_W'(1));
               result_idx_in = bottom_ff;
            end
            state_in = ST_DONE;
         end
         ST_POP_RD: begin
            if ((count_ff == '0) ||
                ((end_ff == END_TOP) && (top_ff >= TOP_EDGE_U)) ||
                ((end_ff == END_BOTTOM) && (bottom_ff == '0))) begin
               result_idx_in = (end_ff == END_TOP) ? top_ff : bottom_ff;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_POP_UPD;
            end
         end
         ST_POP_UPD: begin
            if (ram_rd_data == '0) begin
               result_idx_in = (end_ff == END_TOP) ? top_ff : bottom_ff;
               state_in      = ST_DONE;
            end else begin
               count_in = count_ff - POP_COUNT_W'(1);
               if (end_ff == END_TOP) begin
                  top_in = (ram_rd_data >= (TOP_EDGE_U - top_ff)) ? TOP_EDGE_U
                                                                  : top_ff + ram_rd_data;
               end else begin
                  bottom_in = (ram_rd_data >= bottom_ff) ? '0 : bottom_ff - ram_rd_data;
               end
               state_in = ST_POP_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = offset_bytes[OFFSET_W-1:0];
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bottom_ff    <= '0;
         top_ff       <= TOP_EDGE_U;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bottom_ff    <= bottom_in;
         top_ff       <= top_in;
      end
      end_ff        <= end_in;
      num_ff        <= num_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      result_idx_ff <= result_idx_in;
      status_ff     <= status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   desa_size_ram #(
      .DEPTH  (TOP_U),
      .ADDR_W (ADDR_W),
      .DATA_W (UNIT_W)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
